### rtl/dns_name_decompressor_assert.svh
// Assertion macros used by the checker of the DNS name decompressor.
`ifndef DNS_NAME_DECOMPRESSOR_ASSERT_SVH
`define DNS_NAME_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, clocked on i_clk and quiet during reset.
`define DND_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dns_name_decompressor check failed");

// Next-cycle implication, clocked on i_clk and quiet during reset.
`define DND_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dns_name_decompressor check failed");

`endif

### rtl/dnd_pkg.sv
// Types and constants of the DNS name decompressor.
package dnd_pkg;

    localparam int ADDR_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 10;
    localparam int LCNT_W   = 6;
    localparam int LLEN_W   = 6;
    localparam int STAT_W   = 3;
    localparam int NLEN_W   = 13;
    localparam int NEXT_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;

    localparam logic [BYTE_W-1:0] PTR_MIN = 8'd192;
    localparam logic [BYTE_W-1:0] RSV_MIN = 8'd64;

    localparam logic [PLEN_W-1:0] PKT_LEN_RESET = 10'd512;
    localparam logic [LCNT_W-1:0] MAX_LBL_RESET = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABELS    = 1'b1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_OUT_OF_PKT  = 3'd1,
        ST_RESERVED    = 3'd2,
        ST_PTR_TO_PTR  = 3'd3,
        ST_TOO_MANY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_PTR2,
        S_TGT,
        S_EMIT,
        S_FIN
    } t_state;

endpackage

### rtl/dnd_req_if.sv
// Request channel: load a packet byte or decode a name.
interface dnd_req_if;
    import dnd_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_byte;

    modport source (output valid, output req_type, output address, output write_byte,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_byte,
                    output ready);
endinterface

### rtl/dnd_res_if.sv
// Result channel: one beat per label plus a closing beat per name.
interface dnd_res_if;
    import dnd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] label_start;
    logic [LLEN_W-1:0] label_length;
    logic              last;
    logic [STAT_W-1:0] status;
    logic [NLEN_W-1:0] name_length;
    logic [NEXT_W-1:0] next_offset;

    modport source (output valid, output label_start, output label_length, output last,
                    output status, output name_length, output next_offset,
                    input ready);
    modport sink   (input valid, input label_start, input label_length, input last,
                    input status, input name_length, input next_offset,
                    output ready);
endinterface

### rtl/dnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/dns_name_decompressor.sv
// Top level of the DNS name decompressor: packet store and name walker.
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    req_type, address, write_byte
//   o_res     out  valid/ready    label_start, label_length, last, status,
//                                 name_length, next_offset
//   i_cfg_*   in   write enable   packet_length (index 0), max_labels (index 1)
//
// A load is written in its accept cycle. A decode spends its accept cycle reading
// the first length byte, then checks each label (S_LEN) and emits it while reading
// the next length byte (S_EMIT), and follows a pointer through S_PTR2 and S_TGT,
// all set by the one registered read port of the packet memory; at the ending byte
// it sends the closing beat (S_FIN). The packet memory needs no clearing after
// reset. A stalled result beat holds the walker until it is taken.
module dns_name_decompressor #(
    parameter int PKT_DEPTH = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dnd_req_if.sink                         i_req,
    dnd_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [dnd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dnd_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);
    import dnd_pkg::*;

    localparam int AW = $clog2(PKT_DEPTH);
    localparam int PW = (AW + 1 > 14) ? AW + 1 : 14;

    t_state              r_state, n_state;
    logic [PLEN_W-1:0]   r_pkt_len;
    logic [LCNT_W-1:0]   r_max_lbl;
    logic [PW-1:0]       r_p, n_p;
    logic [LLEN_W-1:0]   r_hi, n_hi;
    logic [LCNT_W-1:0]   r_count, n_count;
    logic [NLEN_W-1:0]   r_sum, n_sum;
    logic [PW-1:0]       r_resume, n_resume;
    logic                r_jumped, n_jumped;
    logic [PW-1:0]       r_lstart, n_lstart;
    logic [LLEN_W-1:0]   r_llen, n_llen;
    t_status             r_fstat, n_fstat;
    logic [NLEN_W-1:0]   r_fnlen, n_fnlen;
    logic [PW-1:0]       r_fnext, n_fnext;

    logic                r_ovalid, n_ovalid;
    logic [ADDR_W-1:0]   r_o_start, n_o_start;
    logic [LLEN_W-1:0]   r_o_llen, n_o_llen;
    logic                r_o_last, n_o_last;
    logic [STAT_W-1:0]   r_o_stat, n_o_stat;
    logic [NLEN_W-1:0]   r_o_nlen, n_o_nlen;
    logic [NEXT_W-1:0]   r_o_next, n_o_next;

    logic                ram_we;
    logic [PW-1:0]       rd_pos;
    logic [BYTE_W-1:0]   rdata;
    logic [PW-1:0]       len_eff;
    logic [PW-1:0]       addr_ext;
    logic [PW-1:0]       off;
    logic [PW-1:0]       u_a, u_b, u_sum;
    logic                u_ge;
    logic                req_acc, slot_free, cnt_full;
    logic                b_zero, b_ptr, b_rsv;
    logic [NLEN_W-1:0]   ok_nlen;

    dnd_ram #(.WIDTH(BYTE_W), .DEPTH(PKT_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr_ext[AW-1:0]),
        .i_wdata (i_req.write_byte),
        .i_raddr (rd_pos[AW-1:0]),
        .o_rdata (rdata)
    );

    assign len_eff  = (PW'(r_pkt_len) >= PW'(PKT_DEPTH)) ? PW'(PKT_DEPTH) : PW'(r_pkt_len);
    assign addr_ext = PW'(i_req.address);
    assign off      = PW'({r_hi, rdata});
    assign req_acc  = i_req.valid && i_req.ready;
    assign slot_free = !r_ovalid || o_res.ready;
    assign cnt_full = (r_count >= r_max_lbl);
    assign b_zero   = (rdata == '0);
    assign b_ptr    = (rdata >= PTR_MIN);
    assign b_rsv    = (rdata >= RSV_MIN);
    assign ok_nlen  = (r_count != '0) ? r_sum : NLEN_W'(1);

    // Shared add-and-compare unit against the packet length.
    always_comb begin
        case (r_state)
            S_IDLE:  u_a = addr_ext;
            S_PTR2:  u_a = off;
            default: u_a = r_p;
        endcase
        if ((r_state == S_LEN || r_state == S_TGT) && !b_ptr) begin
            u_b = PW'(rdata[LLEN_W-1:0]);
        end else begin
            u_b = '0;
        end
    end
    assign u_sum = u_a + u_b;
    assign u_ge  = (u_sum >= len_eff);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc && i_req.req_type == REQ_DECODE) begin
                    n_state = u_ge ? S_FIN : S_LEN;
                end
            end
            S_LEN: begin
                if (b_zero || b_rsv && !b_ptr) begin
                    n_state = S_FIN;
                end else if (b_ptr) begin
                    n_state = u_ge ? S_FIN : S_PTR2;
                end else begin
                    n_state = (u_ge || cnt_full) ? S_FIN : S_EMIT;
                end
            end
            S_PTR2: begin
                n_state = u_ge ? S_FIN : S_TGT;
            end
            S_TGT: begin
                if (b_zero || b_rsv) begin
                    n_state = S_FIN;
                end else begin
                    n_state = (u_ge || cnt_full) ? S_FIN : S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_LEN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we   = 1'b0;
        rd_pos   = r_p;
        n_p      = r_p;
        n_hi     = r_hi;
        n_count  = r_count;
        n_sum    = r_sum;
        n_resume = r_resume;
        n_jumped = r_jumped;
        n_lstart = r_lstart;
        n_llen   = r_llen;
        n_fstat  = r_fstat;
        n_fnlen  = r_fnlen;
        n_fnext  = r_fnext;
        n_ovalid = r_ovalid && !o_res.ready;
        n_o_start = r_o_start;
        n_o_llen  = r_o_llen;
        n_o_last  = r_o_last;
        n_o_stat  = r_o_stat;
        n_o_nlen  = r_o_nlen;
        n_o_next  = r_o_next;
        case (r_state)
            S_IDLE: begin
                rd_pos = addr_ext;
                if (req_acc) begin
                    if (i_req.req_type == REQ_LOAD) begin
                        ram_we = (addr_ext < PW'(PKT_DEPTH));
                    end else begin
                        n_p      = addr_ext + 1'b1;
                        n_count  = '0;
                        n_sum    = '0;
                        n_resume = '0;
                        n_jumped = 1'b0;
                        n_fstat  = ST_OUT_OF_PKT;
                        n_fnlen  = '0;
                        n_fnext  = '0;
                    end
                end
            end
            S_LEN, S_TGT: begin
                n_fnlen = '0;
                n_fnext = '0;
                if (b_zero) begin
                    n_fstat = ST_OK;
                    n_fnlen = ok_nlen;
                    n_fnext = (r_jumped || r_state == S_TGT) ? r_resume : r_p;
                end else if (b_ptr && r_state == S_LEN) begin
                    n_fstat = ST_OUT_OF_PKT;
                    rd_pos  = r_p;
                    n_p     = r_p + 1'b1;
                    n_hi    = rdata[LLEN_W-1:0];
                end else if (b_rsv) begin
                    n_fstat = (r_state == S_TGT) ? ST_PTR_TO_PTR : ST_RESERVED;
                end else if (u_ge) begin
                    n_fstat = ST_OUT_OF_PKT;
                end else if (cnt_full) begin
                    n_fstat = ST_TOO_MANY;
                end else begin
                    n_lstart = r_p;
                    n_llen   = rdata[LLEN_W-1:0];
                    n_p      = u_sum;
                    n_count  = r_count + 1'b1;
                    n_sum    = r_sum + NLEN_W'(rdata[LLEN_W-1:0]) + NLEN_W'(1);
                end
            end
            S_PTR2: begin
                if (!r_jumped) begin
                    n_resume = r_p;
                    n_jumped = 1'b1;
                end
                n_fstat = ST_OUT_OF_PKT;
                n_fnlen = '0;
                n_fnext = '0;
                rd_pos  = off;
                n_p     = off + 1'b1;
            end
            S_EMIT: begin
                if (slot_free) begin
                    rd_pos    = r_p;
                    n_p       = r_p + 1'b1;
                    n_ovalid  = 1'b1;
                    n_o_start = r_lstart[ADDR_W-1:0];
                    n_o_llen  = r_llen;
                    n_o_last  = 1'b0;
                    n_o_stat  = ST_OK;
                    n_o_nlen  = '0;
                    n_o_next  = '0;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_o_start = '0;
                    n_o_llen  = '0;
                    n_o_last  = 1'b1;
                    n_o_stat  = r_fstat;
                    n_o_nlen  = r_fnlen;
                    n_o_next  = r_fnext[NEXT_W-1:0];
                end
            end
            default: begin
                rd_pos = r_p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_pkt_len <= PKT_LEN_RESET;
            r_max_lbl <= MAX_LBL_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PACKET_LENGTH: r_pkt_len <= i_cfg_wdata;
                    CFG_MAX_LABELS:    r_max_lbl <= i_cfg_wdata[LCNT_W-1:0];
                    default:           r_pkt_len <= r_pkt_len;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_hi      <= n_hi;
        r_count   <= n_count;
        r_sum     <= n_sum;
        r_resume  <= n_resume;
        r_jumped  <= n_jumped;
        r_lstart  <= n_lstart;
        r_llen    <= n_llen;
        r_fstat   <= n_fstat;
        r_fnlen   <= n_fnlen;
        r_fnext   <= n_fnext;
        r_o_start <= n_o_start;
        r_o_llen  <= n_o_llen;
        r_o_last  <= n_o_last;
        r_o_stat  <= n_o_stat;
        r_o_nlen  <= n_o_nlen;
        r_o_next  <= n_o_next;
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.label_start  = r_o_start;
    assign o_res.label_length = r_o_llen;
    assign o_res.last         = r_o_last;
    assign o_res.status       = r_o_stat;
    assign o_res.name_length  = r_o_nlen;
    assign o_res.next_offset  = r_o_next;
endmodule

### rtl/dnd_checker.sv
// Port-level checker of the DNS name decompressor and its bind.
`include "dns_name_decompressor_assert.svh"

module dnd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic                         i_req_type,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  logic [dnd_pkg::ADDR_W-1:0]   i_res_start,
    input  logic [dnd_pkg::LLEN_W-1:0]   i_res_llen,
    input  logic                         i_res_last,
    input  logic [dnd_pkg::STAT_W-1:0]   i_res_status,
    input  logic [dnd_pkg::NLEN_W-1:0]   i_res_nlen,
    input  logic [dnd_pkg::NEXT_W-1:0]   i_res_next
);
    import dnd_pkg::*;

    localparam int PAY_W = ADDR_W + LLEN_W + 1 + STAT_W + NLEN_W + NEXT_W;

    logic             dec_acc;
    logic             lbl_beat;
    logic             fail_beat;
    logic             res_stall;
    logic [PAY_W-1:0] res_pay;

    assign dec_acc   = i_req_valid && i_req_ready && i_req_type == REQ_DECODE;
    assign lbl_beat  = i_res_valid && !i_res_last;
    assign fail_beat = i_res_valid && i_res_last && i_res_status != ST_OK;
    assign res_stall = i_res_valid && !i_res_ready;
    assign res_pay   = {i_res_start, i_res_llen, i_res_last, i_res_status, i_res_nlen,
                        i_res_next};

    // A label beat always reports success and a nonempty label.
    `DND_ASSERT_IMP(a_label_ok, lbl_beat, i_res_status == ST_OK && i_res_llen != '0)
    // A failed name closes with zero length and zero resume offset.
    `DND_ASSERT_IMP(a_fail_zero, fail_beat, i_res_nlen == '0 && i_res_next == '0)
    // Accepting a decode beat takes the walker out of idle.
    `DND_ASSERT_NXT(a_decode_busy, dec_acc, !i_req_ready)
    // A stalled result beat stays and holds its payload.
    `DND_ASSERT_NXT(a_res_hold, res_stall, i_res_valid && $stable(res_pay))
endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_start  (o_res.label_start),
    .i_res_llen   (o_res.label_length),
    .i_res_last   (o_res.last),
    .i_res_status (o_res.status),
    .i_res_nlen   (o_res.name_length),
    .i_res_next   (o_res.next_offset)
);

### tb/sv/dns_name_decompressor_test.sv
// Self-checking testbench for the DNS name decompressor: directed table, then random packets.
module dns_name_decompressor_test;
    import dnd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PKT_BYTES   = 512;
    localparam int unsigned LEN_MASK    = 'h3F;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned SETTLE_CYC  = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] lbl_start;
        logic [LLEN_W-1:0] lbl_len;
        logic              last;
        t_status           status;
        logic [NLEN_W-1:0] name_len;
        logic [NEXT_W-1:0] next_off;
    } t_name_beat;

    typedef enum {ROW_LOAD, ROW_DECODE, ROW_CFG} t_row_kind;

    // For ROW_CFG, a is packet_length and d is max_labels.
    typedef struct {
        t_row_kind   kind;
        int unsigned a;
        int unsigned d;
        bit          typed;
        t_status     st;
        int unsigned nlen;
        int unsigned nxt;
    } t_stim_row;

    t_stim_row dir_rows [37] = '{
        '{ROW_LOAD,     0,   1, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     1, 255, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     2,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     3, 192, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     4,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     5, 192, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     6,   2, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     7,  64, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     8, 191, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,     9, 192, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    10,   3, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    11,   1, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    12,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    13, 192, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    14,  11, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    15, 255, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,    16, 255, 1'b0, ST_OK,         0, 0},
        '{ROW_LOAD,   511,  63, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   2,   0, 1'b1, ST_OK,         1, 3},
        '{ROW_DECODE,   0,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   3,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   5,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   7,   0, 1'b1, ST_RESERVED,   0, 0},
        '{ROW_DECODE,   8,   0, 1'b1, ST_RESERVED,   0, 0},
        '{ROW_DECODE,   9,   0, 1'b1, ST_PTR_TO_PTR, 0, 0},
        '{ROW_DECODE,  11,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,  15,   0, 1'b1, ST_OUT_OF_PKT, 0, 0},
        '{ROW_DECODE, 511,   0, 1'b1, ST_OUT_OF_PKT, 0, 0},
        '{ROW_CFG,      0,  63, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   0,   0, 1'b1, ST_OUT_OF_PKT, 0, 0},
        '{ROW_CFG,      4,   0, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   3,   0, 1'b1, ST_OUT_OF_PKT, 0, 0},
        '{ROW_DECODE,   0,   0, 1'b1, ST_TOO_MANY,   0, 0},
        '{ROW_CFG,      2,  63, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   0,   0, 1'b1, ST_OUT_OF_PKT, 0, 0},
        '{ROW_CFG,   1023,  63, 1'b0, ST_OK,         0, 0},
        '{ROW_DECODE,   0,   0, 1'b0, ST_OK,         0, 0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    dnd_req_if req_ch ();
    dnd_res_if res_ch ();

    dns_name_decompressor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    logic [BYTE_W-1:0] pkt_mem   [PKT_BYTES];
    bit                pkt_known [PKT_BYTES];
    logic [PLEN_W-1:0] cur_pkt_len = PKT_LEN_RESET;
    logic [LCNT_W-1:0] cur_max_lbl = MAX_LBL_RESET;
    bit                walk_clean;
    t_name_beat        pending_beats [$];
    int unsigned       name_starts [$];
    int unsigned       snd_idle_pct  = 0;
    int unsigned       rcv_stall_pct = 0;
    int unsigned       mismatches    = 0;
    int unsigned       cycles        = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned pkt_byte(input int unsigned a);
        if (!pkt_known[a]) begin
            walk_clean = 1'b0;
        end
        return pkt_mem[a];
    endfunction

    // Walks the name at origin and returns its label beats and closing beat.
    function automatic void walk_name(input int unsigned origin, output t_name_beat beats[$]);
        int unsigned lim, p, b, off, count, text_len, resume;
        bit          jumped;
        t_status     st;
        t_name_beat  bt;
        beats      = {};
        walk_clean = 1'b1;
        lim      = (cur_pkt_len < PKT_BYTES) ? cur_pkt_len : PKT_BYTES;
        st       = ST_OK;
        count    = 0;
        text_len = 0;
        resume   = 0;
        jumped   = 1'b0;
        b        = 0;
        p        = origin;
        if (p >= lim) begin
            st = ST_OUT_OF_PKT;
        end else begin
            b = pkt_byte(p);
            p++;
        end
        while (st == ST_OK && b != 0) begin
            if (b >= PTR_MIN) begin
                if (p >= lim) begin
                    st = ST_OUT_OF_PKT;
                    break;
                end
                off = ((b & LEN_MASK) << 8) | pkt_byte(p);
                p++;
                if (!jumped) begin
                    resume = p;
                    jumped = 1'b1;
                end
                if (off >= lim) begin
                    st = ST_OUT_OF_PKT;
                    break;
                end
                b = pkt_byte(off);
                if (b >= RSV_MIN) begin
                    st = ST_PTR_TO_PTR;
                    break;
                end
                if (b == 0) break;
                p = off + 1;
            end else if (b >= RSV_MIN) begin
                st = ST_RESERVED;
                break;
            end
            if (p + b >= lim) begin
                st = ST_OUT_OF_PKT;
                break;
            end
            if (count >= cur_max_lbl) begin
                st = ST_TOO_MANY;
                break;
            end
            bt           = '0;
            bt.lbl_start = ADDR_W'(p);
            bt.lbl_len   = LLEN_W'(b);
            beats.push_back(bt);
            count++;
            text_len += b + 1;
            p += b;
            b = pkt_byte(p);
            p++;
        end
        bt        = '0;
        bt.last   = 1'b1;
        bt.status = st;
        if (st == ST_OK) begin
            bt.name_len = NLEN_W'((count != 0) ? text_len : 1);
            bt.next_off = NEXT_W'(jumped ? resume : p);
        end
        beats.push_back(bt);
    endfunction

    task automatic send_item(input logic kind, input int unsigned a, input int unsigned d);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.address    <= ADDR_W'(a);
        req_ch.write_byte <= BYTE_W'(d);
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic load_byte(input int unsigned a, input int unsigned d);
        send_item(REQ_LOAD, a, d);
        pkt_mem[a]   = BYTE_W'(d);
        pkt_known[a] = 1'b1;
    endtask

    task automatic decode_at(input int unsigned a, output bit sent);
        t_name_beat beats [$];
        walk_name(a, beats);
        sent = walk_clean;
        if (sent) begin
            send_item(REQ_DECODE, a, $urandom_range(255));
            foreach (beats[i]) pending_beats.push_back(beats[i]);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_regs(input int unsigned pl, input int unsigned ml);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_PACKET_LENGTH;
        cfg_wdata <= pl[PLEN_W-1:0];
        @(posedge i_clk);
        cfg_idx   <= CFG_MAX_LABELS;
        cfg_wdata <= CFG_DAT_W'(ml[LCNT_W-1:0]);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_pkt_len = pl[PLEN_W-1:0];
        cur_max_lbl = ml[LCNT_W-1:0];
    endtask

    // Lays down one name as a run of loads, then decodes it. Some names end in a
    // pointer to an earlier name or to themselves, and some get a corrupted byte.
    task automatic build_name(inout int unsigned sent);
        int unsigned nlab, lbl, size, base, tgt;
        logic [7:0]  bytes [$];
        bit          use_ptr, self_ptr, ok;
        nlab     = ($urandom_range(7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        use_ptr  = $urandom_range(1) && name_starts.size() != 0;
        self_ptr = ($urandom_range(11) == 0);
        for (int i = 0; i < nlab && bytes.size() < 400; i++) begin
            lbl = ($urandom_range(9) == 0) ? $urandom_range(7, 63) : $urandom_range(1, 6);
            bytes.push_back(8'(lbl));
            repeat (lbl) bytes.push_back(8'($urandom_range(255)));
        end
        size = bytes.size() + ((use_ptr || self_ptr) ? 2 : 1);
        base = $urandom_range(0, PKT_BYTES - size);
        if (use_ptr || self_ptr) begin
            tgt = self_ptr ? base : name_starts[$urandom_range(name_starts.size() - 1)];
            if ($urandom_range(9) == 0) begin
                bytes.push_back(8'(PTR_MIN | $urandom_range(63)));
            end else begin
                bytes.push_back(8'(PTR_MIN | (tgt >> 8)));
            end
            bytes.push_back(8'(tgt));
        end else begin
            bytes.push_back(8'd0);
        end
        if ($urandom_range(7) == 0) begin
            bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom_range(255));
        end
        foreach (bytes[i]) begin
            load_byte(base + i, bytes[i]);
            sent++;
        end
        decode_at(base, ok);
        if (ok) sent++;
        name_starts.push_back(base);
        if (name_starts.size() > 16) void'(name_starts.pop_front());
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned sent, pick, a;
        bit          ok;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 3) settle();
            if (pick < 65) begin
                build_name(sent);
            end else if (pick < 82) begin
                load_byte($urandom_range(PKT_BYTES - 1), $urandom_range(255));
                sent++;
            end else begin
                if (pick < 92 && name_starts.size() != 0) begin
                    a = name_starts[$urandom_range(name_starts.size() - 1)];
                end else begin
                    a = $urandom_range(PKT_BYTES - 1);
                end
                decode_at(a, ok);
                if (ok) sent++;
            end
        end
    endtask

    initial begin
        t_name_beat got, want;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got.lbl_start = res_ch.label_start;
                got.lbl_len   = res_ch.label_length;
                got.last      = res_ch.last;
                got.status    = t_status'(res_ch.status);
                got.name_len  = res_ch.name_length;
                got.next_off  = res_ch.next_offset;
                if (pending_beats.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result beat: start %0d len %0d last %0d status %0d",
                                 got.lbl_start, got.lbl_len, got.last, got.status);
                    end
                    mismatches++;
                end else begin
                    want = pending_beats.pop_front();
                    if (got.lbl_start !== want.lbl_start || got.lbl_len !== want.lbl_len ||
                        got.last !== want.last || got.status !== want.status ||
                        got.name_len !== want.name_len || got.next_off !== want.next_off) begin
                        if (mismatches < 10) begin
                            $display("beat mismatch (exp/got): start %0d/%0d len %0d/%0d",
                                     want.lbl_start, got.lbl_start, want.lbl_len, got.lbl_len);
                            $display("  last %0d/%0d status %0d/%0d name_len %0d/%0d next %0d/%0d",
                                     want.last, got.last, want.status, got.status,
                                     want.name_len, got.name_len, want.next_off, got.next_off);
                        end
                        mismatches++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("dns_name_decompressor verification failed");
        $finish;
    end

    initial begin
        t_name_beat bt;
        bit         ok;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_LOAD;
        req_ch.address    <= '0;
        req_ch.write_byte <= '0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_PACKET_LENGTH;
        cfg_wdata         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_LOAD: begin
                    load_byte(dir_rows[i].a, dir_rows[i].d);
                end
                ROW_CFG: begin
                    set_regs(dir_rows[i].a, dir_rows[i].d);
                end
                default: begin
                    if (dir_rows[i].typed) begin
                        send_item(REQ_DECODE, dir_rows[i].a, 0);
                        bt          = '0;
                        bt.last     = 1'b1;
                        bt.status   = dir_rows[i].st;
                        bt.name_len = NLEN_W'(dir_rows[i].nlen);
                        bt.next_off = NEXT_W'(dir_rows[i].nxt);
                        pending_beats.push_back(bt);
                    end else begin
                        decode_at(dir_rows[i].a, ok);
                    end
                end
            endcase
        end

        set_regs(512, 63);
        run_random(30);
        settle();
        run_random(30);

        set_regs(300, 5);
        snd_idle_pct = 75;
        run_random(50);

        set_regs(1023, 63);
        snd_idle_pct  = 0;
        rcv_stall_pct = 75;
        run_random(50);

        set_regs(512, 1);
        snd_idle_pct  = 19;
        rcv_stall_pct = 19;
        run_random(40);

        set_regs(1, 20);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        run_random(15);

        set_regs(460, 40);
        snd_idle_pct  = 19;
        rcv_stall_pct = 19;
        run_random(60);

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("dns_name_decompressor verification clean");
        end else begin
            $display("dns_name_decompressor verification failed");
        end
        $finish;
    end

endmodule
